/* hdl/modular_exponentiation_defines.svh */
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MEXP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Width default, sequencer states and the status bundle of the multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

	// Default operand width.
	localparam int MEXP_WIDTH = 32;

	// Sequencer states of the exponentiation controller.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SCAN,
		ST_SQUARE,
		ST_MULT,
		ST_DONE
	} state_t;

	// Status of the shared modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

/* hdl/mexp_mulmod.sv */
// ----------------------------------------------------------------------------
// Iterative modular multiplier
// Computes x * y mod n one bit of y per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
	parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDTH-1:0]  x,
	input  logic [WIDTH-1:0]  y,
	input  logic [WIDTH-1:0]  n,
	output mexp_pkg::mm_stat_t stat,
	output logic [WIDTH-1:0]  result
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] x_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] n_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+2:0] diff1;
	logic [WIDTH+2:0] diff2;
	logic [WIDTH-1:0] acc_next;

	// One step: 2*acc plus x when the bit is set. The sum stays below 3n, so
	// subtracting n or 2n once brings it back into range. A zero modulus
	// stands for 2^WIDTH, where the low bits are the answer.
	always_comb begin
		sum   = {1'b0, acc_q, 1'b0} + {2'b00, (y_q[WIDTH-1] ? x_q : '0)};
		diff1 = {1'b0, sum} - {3'b000, n_q};
		diff2 = {1'b0, sum} - {2'b00, n_q, 1'b0};
		if (n_q == '0) begin
			acc_next = sum[WIDTH-1:0];
		end else if (!diff2[WIDTH+2]) begin
			acc_next = diff2[WIDTH-1:0];
		end else if (!diff1[WIDTH+2]) begin
			acc_next = diff1[WIDTH-1:0];
		end else begin
			acc_next = sum[WIDTH-1:0];
		end
	end

	// Control: a run steps once per bit of y, then done pulses for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: operands are captured at start, y shifts out one bit a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			n_q   <= n;
		end else if (busy_q) begin
			acc_q <= acc_next;
			y_q   <= {y_q[WIDTH-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = acc_q;

endmodule

/* hdl/modular_exponentiation.sv */
// Sequence: a zero exponent goes straight to loading the output register. Otherwise the
// base is first reduced by the modulus, each leading zero bit takes a scan step, and each bit
// from the leading one takes a scan step, a square (not for the leading bit) and, when set,
// a multiply; the output register is then loaded.
// Items: one item at a time; a new input is taken only once the sequencer is idle again.
// Reset: arst_n clears the sequencer and output valid; the modulus resets to 1.
// ----------------------------------------------------------------------------
// Modular exponentiation
// Left-to-right binary exponentiation of base modulo a configured modulus.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modular_exponentiation #(
	parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	// Configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [WIDTH-1:0] modulus,
	// Input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] base,
	input  logic [WIDTH-1:0] exponent,
	// Output channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] power_result
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	state_t           state_q;
	state_t           state_d;
	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] exp_q;
	logic [CNT_W-1:0] bit_cnt_q;
	logic             started_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] res_q;

	logic             mm_start;
	logic [WIDTH-1:0] mm_x;
	logic [WIDTH-1:0] mm_y;
	logic [WIDTH-1:0] mm_result;
	mm_stat_t         mm_stat;
	logic             accept;
	logic             last_bit;
	logic             bit_adv;
	logic             out_load;
	logic [WIDTH-1:0] one_mod;
	logic             mm_wait;

	assign accept   = in_valid && !in_stall;
	assign last_bit = (bit_cnt_q == '0);
	// The value one reduced by the modulus: zero when the modulus is one.
	assign one_mod  = (n_q == WIDTH'(1)) ? '0 : WIDTH'(1);

	// Shared modular multiplier.
	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.x     (mm_x),
		.y     (mm_y),
		.n     (n_q),
		.stat  (mm_stat),
		.result(mm_result)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (exponent == '0) ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mm_stat.done) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (started_q) begin
					state_d = ST_SQUARE;
				end else if (exp_q[WIDTH-1]) begin
					state_d = ST_MULT;
				end else if (last_bit) begin
					state_d = ST_DONE;
				end
			end
			ST_SQUARE: begin
				if (mm_stat.done) begin
					if (exp_q[WIDTH-1]) begin
						state_d = ST_MULT;
					end else begin
						state_d = last_bit ? ST_DONE : ST_SCAN;
					end
				end
			end
			ST_MULT: begin
				if (mm_stat.done) begin
					state_d = last_bit ? ST_DONE : ST_SCAN;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: multiplier launch, operands, bit advance and output load.
	always_comb begin
		mm_start = 1'b0;
		mm_x     = acc_q;
		mm_y     = acc_q;
		bit_adv  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mm_start = accept && (exponent != '0);
				mm_x     = WIDTH'(1);
				mm_y     = base;
			end
			ST_REDUCE: begin
			end
			ST_SCAN: begin
				mm_start = started_q || exp_q[WIDTH-1];
				mm_x     = started_q ? acc_q : a_q;
				bit_adv  = !started_q && !exp_q[WIDTH-1];
			end
			ST_SQUARE: begin
				// The squared value feeds the multiply straight from the unit.
				mm_start = mm_stat.done && exp_q[WIDTH-1];
				mm_x     = a_q;
				mm_y     = mm_result;
				bit_adv  = mm_stat.done && !exp_q[WIDTH-1];
			end
			ST_MULT: begin
				bit_adv = mm_stat.done;
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= WIDTH'(1);
			started_q   <= 1'b0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				n_q <= modulus;
			end
			if (accept) begin
				started_q <= 1'b0;
				bit_cnt_q <= CNT_W'(WIDTH - 1);
			end else begin
				if (state_q == ST_SCAN && !started_q && exp_q[WIDTH-1]) begin
					started_q <= 1'b1;
				end
				if (bit_adv) begin
					bit_cnt_q <= bit_cnt_q - 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= exponent;
			acc_q <= WIDTH'(1);
		end else begin
			if (state_q == ST_REDUCE && mm_stat.done) begin
				a_q   <= mm_result;
				acc_q <= one_mod;
			end
			if ((state_q == ST_SQUARE || state_q == ST_MULT) && mm_stat.done) begin
				acc_q <= mm_result;
			end
			if (bit_adv) begin
				exp_q <= {exp_q[WIDTH-2:0], 1'b0};
			end
		end
		if (out_load) begin
			res_q <= acc_q;
		end
	end

	// A pending configuration write takes the idle cycle ahead of any input transfer.
	assign in_stall     = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready    = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign power_result = res_q;

	assign mm_wait = (state_q == ST_REDUCE) || (state_q == ST_SQUARE) || (state_q == ST_MULT);

	// Checks on the sequencer and the output register.
	`MEXP_ASSERT(a_done_in_wait, !mm_stat.done || mm_wait, "Multiplier finished outside a wait")
	`MEXP_ASSERT(a_start_idle, !mm_start || !mm_stat.busy, "Multiplier started while busy")
	`MEXP_ASSERT(a_acc_reduced, !(state_q == ST_SCAN && n_q != '0) || acc_q < n_q, "Acc not reduced")
	`MEXP_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall, out_valid_q && $stable(res_q), "Result moved")

endmodule
